// ----- hw/rtl/ght_pkg.sv -----
// ============================================================================
// ght_pkg: shared types and constants of the generational handle table
// request codes, status codes, handle layout and the stored entry format
// ============================================================================
`default_nettype none

package ght_pkg;

    // request codes
    localparam logic [1:0] MODE_ALLOC    = 2'd0;
    localparam logic [1:0] MODE_VALIDATE = 2'd1;
    localparam logic [1:0] MODE_RELEASE  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // handle layout
    localparam logic [7:0]  HANDLE_TAG = 8'h41;
    localparam logic [23:0] GEN_ONE    = 24'h000001;
    localparam logic [23:0] GEN_MAX    = 24'hffffff;

    // busy bitmap rows are at most this wide
    localparam int MAX_ROW_W = 64;
    localparam int ROW_SH    = 6;

    // width of the slot field on the result
    localparam int SLOT_OUT_W = 6;

    typedef struct packed {
        logic [23:0] gen;
        logic [31:0] owner;
    } entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ght_entry_store.sv -----
// ============================================================================
// ght_entry_store: per-slot generation and owner memory
// one write port, one read port, registered read data
// ============================================================================
`default_nettype none

module ght_entry_store
    import ght_pkg::*;
#(
    parameter int SLOTS = 64,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
)
(
    input  wire logic             clk,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire entry_t           wr_data
);

    entry_t mem [SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ght_busy_map.sv -----
// ============================================================================
// ght_busy_map: occupancy bitmap of the slot table
// rows of up to 64 busy bits in a memory, one full flag per row in flops,
// lowest row with a free slot found from the flags
// ============================================================================
`default_nettype none

module ght_busy_map
    import ght_pkg::*;
#(
    parameter int SLOTS = 64,
    localparam int ROW_W  = (SLOTS < MAX_ROW_W) ? SLOTS : MAX_ROW_W,
    localparam int ROWS   = (SLOTS + ROW_W - 1) / ROW_W,
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              rd_en,
    input  wire logic [ROW_AW-1:0] rd_row,
    output logic      [ROW_W-1:0]  rd_bits,
    input  wire logic              wr_en,
    input  wire logic [ROW_AW-1:0] wr_row,
    input  wire logic [ROW_W-1:0]  wr_bits,
    output logic                   free_any,
    output logic      [ROW_AW-1:0] free_row
);

    logic [ROW_W-1:0]  mem [ROWS];
    logic [ROW_W-1:0]  rd_data_reg;
    logic [ROW_AW-1:0] rd_row_reg;
    logic [ROWS-1:0]   full_reg;

    // bits past the last slot read as busy
    function automatic logic [ROW_W-1:0] pad_mask(input logic [ROW_AW-1:0] r);
        logic [ROW_W-1:0] m;
        m = '0;
        for (int b = 0; b < ROW_W; b++)
        begin
            m[b] = ((32'(r) * 32'(ROW_W) + 32'(b)) >= 32'(SLOTS));
        end
        return m;
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_row] <= wr_bits;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_row];
            rd_row_reg  <= rd_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
        end
        else if (wr_en)
        begin
            full_reg[wr_row] <= &(wr_bits | pad_mask(wr_row));
        end
    end

    assign rd_bits = rd_data_reg | pad_mask(rd_row_reg);

    // lowest row that still has a free slot
    always_comb
    begin
        free_any = 1'b0;
        free_row = '0;
        for (int r = ROWS - 1; r >= 0; r--)
        begin
            if (!full_reg[r])
            begin
                free_any = 1'b1;
                free_row = ROW_AW'(r);
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/generational_handle_table.sv -----
// ============================================================================
// generational_handle_table: slot table handing out typed generational handles
// allocate, validate and release of 64-bit handles over SLOTS slots
// ============================================================================
// One request is taken at a time: a transfer happens when start is high and
// busy is low. Validate and release pass through the check state before the
// result, allocate through the row and then the generation state; a request
// refused on its face (null owner, full table, malformed handle, unused mode)
// gives its result in the cycle after the transfer. The sequence follows
// from the registered reads of the busy bitmap and entry memories: allocate
// reads the bitmap row, then the entry, then writes back. busy drops in the
// cycle the result is shown, so a new request may be taken while the previous
// result is on the ports. Each result is shown for exactly one cycle with done
// high; the receiver cannot stall. After reset the block runs a clearing pass
// (busy is high) that sets every generation to 1 and frees every slot.
// ============================================================================
`default_nettype none

module generational_handle_table
    import ght_pkg::*;
#(
    parameter int SLOTS = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  mode,
    input  wire logic [63:0] handle,
    input  wire logic [31:0] owner,
    output logic             done,
    output logic [1:0]       status,
    output logic [63:0]      handle_out,
    output logic [5:0]       slot_out
);

    localparam int ROW_W  = (SLOTS < MAX_ROW_W) ? SLOTS : MAX_ROW_W;
    localparam int ROWS   = (SLOTS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BIT_W  = (ROW_W > 1) ? $clog2(ROW_W) : 1;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // sequencer states
    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_ALLOC_ROW = 3'd2;
    localparam logic [2:0] S_ALLOC_GEN = 3'd3;
    localparam logic [2:0] S_CHECK     = 3'd4;

    // control
    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic             done_reg, done_next;

    // request context
    logic              rel_reg, rel_next;
    logic [31:0]       owner_reg, owner_next;
    logic [23:0]       gen_reg, gen_next;
    logic [ROW_AW-1:0] row_reg, row_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    // result
    logic [1:0]            status_reg, status_next;
    logic [63:0]           hout_reg, hout_next;
    logic [SLOT_OUT_W-1:0] slot_reg, slot_next;

    // bitmap and entry memory ports
    logic              b_rd_en, b_wr_en, free_any;
    logic [ROW_AW-1:0] b_rd_row, b_wr_row, free_row;
    logic [ROW_W-1:0]  b_rd_bits, b_wr_bits;
    logic              e_rd_en, e_wr_en;
    logic [IDX_W-1:0]  e_rd_addr, e_wr_addr;
    entry_t            e_rd_data, e_wr_data;

    // handle decode
    logic [31:0] h_low, h_idx;
    logic [23:0] h_gen;
    logic        h_ok;

    // bitmap search inside the fetched row
    logic [BIT_W-1:0] free_bit, chk_bit;
    logic [IDX_W-1:0] new_idx;
    logic             hit;

    function automatic logic [ROW_AW-1:0] row_of(input logic [IDX_W-1:0] i);
        if (ROWS == 1)
        begin
            return '0;
        end
        return ROW_AW'(i >> ROW_SH);
    endfunction

    function automatic logic [BIT_W-1:0] bit_of(input logic [IDX_W-1:0] i);
        if (ROWS == 1)
        begin
            return BIT_W'(i);
        end
        return BIT_W'(i & IDX_W'(ROW_W - 1));
    endfunction

    function automatic logic [IDX_W-1:0] slot_of(input logic [ROW_AW-1:0] r,
                                                 input logic [BIT_W-1:0]  b);
        if (ROWS == 1)
        begin
            return IDX_W'(b);
        end
        return (IDX_W'(r) << ROW_SH) | IDX_W'(b);
    endfunction

    // position of the lowest clear bit
    function automatic logic [BIT_W-1:0] first_zero(input logic [ROW_W-1:0] v);
        logic [BIT_W-1:0] p;
        p = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (!v[i])
            begin
                p = BIT_W'(i);
            end
        end
        return p;
    endfunction

    ght_busy_map #(
        .SLOTS(SLOTS)
    ) u_busy_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (b_rd_en),
        .rd_row   (b_rd_row),
        .rd_bits  (b_rd_bits),
        .wr_en    (b_wr_en),
        .wr_row   (b_wr_row),
        .wr_bits  (b_wr_bits),
        .free_any (free_any),
        .free_row (free_row)
    );

    ght_entry_store #(
        .SLOTS(SLOTS)
    ) u_entry_store (
        .clk     (clk),
        .rd_en   (e_rd_en),
        .rd_addr (e_rd_addr),
        .rd_data (e_rd_data),
        .wr_en   (e_wr_en),
        .wr_addr (e_wr_addr),
        .wr_data (e_wr_data)
    );

    // handle fields: tag, generation, index plus one
    assign h_low = handle[31:0];
    assign h_gen = handle[55:32];
    assign h_idx = h_low - 32'd1;
    assign h_ok  = (handle[63:56] == HANDLE_TAG) && (h_low != 32'd0)
                   && (h_gen != 24'd0) && (h_idx < 32'(SLOTS));

    assign free_bit = first_zero(b_rd_bits);
    assign new_idx  = slot_of(row_reg, free_bit);
    assign chk_bit  = bit_of(idx_reg);
    // busy slot, same generation, same owner (a busy slot's stored owner is never null)
    assign hit      = b_rd_bits[chk_bit] && (e_rd_data.gen == gen_reg)
                      && (e_rd_data.owner == owner_reg);

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        done_next    = 1'b0;
        rel_next     = rel_reg;
        owner_next   = owner_reg;
        gen_next     = gen_reg;
        row_next     = row_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        hout_next    = hout_reg;
        slot_next    = slot_reg;

        b_rd_en   = 1'b0;
        b_rd_row  = row_reg;
        b_wr_en   = 1'b0;
        b_wr_row  = row_reg;
        b_wr_bits = b_rd_bits;
        e_rd_en   = 1'b0;
        e_rd_addr = idx_reg;
        e_wr_en   = 1'b0;
        e_wr_addr = idx_reg;
        e_wr_data = e_rd_data;

        unique case (state_reg)
            S_CLEAR:
            begin
                // one slot per cycle: generation 1, busy bit clear
                b_wr_en   = 1'b1;
                b_wr_row  = row_of(clr_cnt_reg);
                b_wr_bits = '0;
                e_wr_en   = 1'b1;
                e_wr_addr = clr_cnt_reg;
                e_wr_data = '{gen: GEN_ONE, owner: 32'd0};
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    owner_next = owner;
                    gen_next   = h_gen;
                    rel_next   = (mode == MODE_RELEASE);
                    idx_next   = IDX_W'(h_idx);
                    // default: refused at once
                    status_next = ST_INVALID;
                    hout_next   = 64'd0;
                    slot_next   = '0;
                    unique case (mode) inside
                        MODE_ALLOC:
                        begin
                            if (owner == 32'd0)
                            begin
                                done_next = 1'b1;
                            end
                            else if (!free_any)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                b_rd_en    = 1'b1;
                                b_rd_row   = free_row;
                                row_next   = free_row;
                                state_next = S_ALLOC_ROW;
                            end
                        end
                        MODE_VALIDATE, MODE_RELEASE:
                        begin
                            if (!h_ok)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                b_rd_en    = 1'b1;
                                b_rd_row   = row_of(IDX_W'(h_idx));
                                row_next   = row_of(IDX_W'(h_idx));
                                e_rd_en    = 1'b1;
                                e_rd_addr  = IDX_W'(h_idx);
                                state_next = S_CHECK;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_ALLOC_ROW:
            begin
                // claim the lowest free bit of the row, fetch its generation
                b_wr_en    = 1'b1;
                b_wr_bits  = b_rd_bits | (ROW_W'(1) << free_bit);
                e_rd_en    = 1'b1;
                e_rd_addr  = new_idx;
                idx_next   = new_idx;
                state_next = S_ALLOC_GEN;
            end

            S_ALLOC_GEN:
            begin
                e_wr_en     = 1'b1;
                e_wr_data   = '{gen: e_rd_data.gen, owner: owner_reg};
                done_next   = 1'b1;
                status_next = ST_OK;
                hout_next   = {HANDLE_TAG, e_rd_data.gen, 32'(idx_reg) + 32'd1};
                slot_next   = SLOT_OUT_W'(idx_reg);
                state_next  = S_IDLE;
            end

            S_CHECK:
            begin
                done_next  = 1'b1;
                hout_next  = 64'd0;
                state_next = S_IDLE;
                if (hit)
                begin
                    status_next = ST_OK;
                    slot_next   = SLOT_OUT_W'(idx_reg);
                    if (rel_reg)
                    begin
                        // free the slot and move its generation on, skipping zero
                        b_wr_en   = 1'b1;
                        b_wr_bits = b_rd_bits & ~(ROW_W'(1) << chk_bit);
                        e_wr_en   = 1'b1;
                        e_wr_data = '{gen: (e_rd_data.gen == GEN_MAX) ? GEN_ONE
                                                : e_rd_data.gen + 24'd1,
                                      owner: e_rd_data.owner};
                    end
                end
                else
                begin
                    status_next = ST_INVALID;
                    slot_next   = '0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    // request context and result payload
    always_ff @(posedge clk)
    begin
        rel_reg    <= rel_next;
        owner_reg  <= owner_next;
        gen_reg    <= gen_next;
        row_reg    <= row_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        hout_reg   <= hout_next;
        slot_reg   <= slot_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign handle_out = hout_reg;
    assign slot_out   = slot_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ght_checker.sv -----
// ============================================================================
// ght_checker: port-level checks of the generational handle table
// bound to the top level
// ============================================================================
`default_nettype none

module ght_checker
    import ght_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        done,
    input wire logic [1:0]  status,
    input wire logic [63:0] handle_out,
    input wire logic [5:0]  slot_out
);

    // every accepted request is either in flight or answered in the next cycle
    a_transfer_answered: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither in flight nor answered");

    // a result only follows a transfer: never two strobes without work between
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start && !busy) || $past(busy)))
        else $error("result strobe without a request");

    // refused requests carry no handle and no slot
    a_refusal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> ((handle_out == 64'd0) && (slot_out == 6'd0)))
        else $error("refused request carries a handle or slot");

    // a handed-out handle is well formed
    a_handle_form: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (handle_out != 64'd0)) |->
            ((status == ST_OK) && (handle_out[63:56] == HANDLE_TAG)
             && (handle_out[55:32] != 24'd0) && (handle_out[31:0] != 32'd0)))
        else $error("malformed handle on result");

endmodule

bind generational_handle_table ght_checker u_ght_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for generational_handle_table
// drives allocate, validate and release requests through the start/busy
// handshake with bursty idling, predicts every reply from a shadow copy of
// the slot table and checks each done strobe field by field, in order
// ============================================================================

module tb;
    import ght_pkg::*;

    localparam int SLOTS        = 64;
    localparam int RANDOM_ITEMS = 1300;
    localparam int FILL_ITEMS   = SLOTS + 8;
    localparam int FILL_EVERY   = 450;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 10;
    localparam int PRINT_CAP    = 40;

    // the one mode code the block does not use
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // one request as queued for the driver; hold makes the driver drain first
    typedef struct {
        logic [1:0]  mode;
        logic [63:0] handle;
        logic [31:0] owner;
        bit          hold;
    } request_t;

    // one reply as the block should show it
    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] handle;
        logic [5:0]  slot;
    } reply_t;

    logic        clk    = 1'b0;
    logic        rst_n  = 1'b0;
    logic        start  = 1'b0;
    logic [1:0]  mode   = '0;
    logic [63:0] handle = '0;
    logic [31:0] owner  = '0;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [63:0] handle_out;
    logic [5:0]  slot_out;

    // shadow slot table
    bit          slot_taken [SLOTS];
    logic [23:0] slot_gen [SLOTS];
    logic [31:0] slot_owner_tag [SLOTS];

    request_t request_q [$];
    reply_t   reply_q [$];

    // transfer and reply counts move only by nonblocking updates, so both
    // clocked blocks see the same values at an edge
    int xfer_count   = 0;
    int result_count = 0;
    int mismatches   = 0;
    int cycle_count  = 0;
    int burst_left   = 0;
    int gap_left     = 0;

    generational_handle_table #(
        .SLOTS(SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .mode(mode),
        .handle(handle),
        .owner(owner),
        .done(done),
        .status(status),
        .handle_out(handle_out),
        .slot_out(slot_out)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [63:0] make_handle(logic [23:0] gen, int idx);
        return {HANDLE_TAG, gen, 32'(idx + 1)};
    endfunction

    // apply one request to the shadow table and return the reply it earns
    function automatic reply_t serve_request(logic [1:0] req_mode, logic [63:0] req_handle,
                                             logic [31:0] req_owner);
        reply_t      r;
        logic [23:0] hgen;
        logic [32:0] idx;
        bit          found;
        r.status = ST_INVALID;
        r.handle = '0;
        r.slot   = '0;
        found    = 1'b0;
        hgen     = req_handle[55:32];
        idx      = {1'b0, req_handle[31:0]} - 33'd1;
        if (req_mode == MODE_ALLOC)
        begin
            // null owner is refused, otherwise lowest free slot or full
            if (req_owner != '0)
            begin
                r.status = ST_FULL;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && !slot_taken[i])
                    begin
                        found             = 1'b1;
                        slot_taken[i]     = 1'b1;
                        slot_owner_tag[i] = req_owner;
                        r.status          = ST_OK;
                        r.handle          = make_handle(slot_gen[i], i);
                        r.slot            = 6'(i);
                    end
                end
            end
        end
        else if (req_mode == MODE_VALIDATE || req_mode == MODE_RELEASE)
        begin
            // tag, nonzero index and generation, range, then the slot itself
            if (req_handle[63:56] == HANDLE_TAG && req_handle[31:0] != '0 && hgen != '0
                && idx < SLOTS)
            begin
                if (slot_taken[idx] && slot_gen[idx] == hgen && slot_owner_tag[idx] == req_owner)
                begin
                    r.status = ST_OK;
                    r.slot   = idx[5:0];
                    if (req_mode == MODE_RELEASE)
                    begin
                        // free the slot and move the generation on, skipping zero
                        slot_taken[idx] = 1'b0;
                        slot_gen[idx]   = (slot_gen[idx] == GEN_MAX) ? GEN_ONE
                                                                     : slot_gen[idx] + 24'd1;
                    end
                end
            end
        end
        return r;
    endfunction

    // random request shaped by the current shadow table: mostly live handles,
    // some of them damaged, plus raw noise
    function automatic request_t random_request();
        request_t rq;
        int       live [$];
        int       pick;
        int       alloc_pct;
        int       roll;
        rq.hold   = 1'b0;
        rq.handle = {$urandom, $urandom};
        rq.owner  = $urandom;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_taken[i])
                live.push_back(i);
        end
        // keep occupancy moving: favor allocate when nearly empty, release when crowded
        alloc_pct = (live.size() < 8) ? 55 : ((live.size() > 40) ? 15 : 35);
        roll = $urandom_range(0, 99);
        if (roll < 3)
            rq.mode = MODE_UNUSED;
        else if (roll < 3 + alloc_pct)
        begin
            rq.mode = MODE_ALLOC;
            if ($urandom_range(0, 29) == 0)
                rq.owner = '0;
            else if (rq.owner == '0)
                rq.owner = 32'd1;
        end
        else
        begin
            rq.mode = ($urandom_range(0, 1) != 0) ? MODE_RELEASE : MODE_VALIDATE;
            if (live.size() != 0 && $urandom_range(0, 99) < 85)
            begin
                pick      = live[$urandom_range(0, live.size() - 1)];
                rq.handle = make_handle(slot_gen[pick], pick);
                rq.owner  = slot_owner_tag[pick];
                case ($urandom_range(0, 23))
                    0: rq.handle[55:32] = slot_gen[pick] - 24'd1;    // stale generation
                    1: rq.handle[55:32] = slot_gen[pick] + 24'd1;
                    2: rq.owner = rq.owner ^ (32'd1 << $urandom_range(0, 31));
                    3: rq.owner = '0;
                    4: rq.handle[63:56] = HANDLE_TAG ^ 8'($urandom_range(1, 255));
                    5: rq.handle[31:0] = '0;
                    6:
                    begin
                        // index past the table
                        if ($urandom_range(0, 1) != 0)
                            rq.handle[31:0] = 32'hffff_ffff;
                        else
                            rq.handle[31:0] = 32'(SLOTS + 1 + $urandom_range(0, 3));
                    end
                    7: rq.handle[55:32] = '0;
                    default: ;
                endcase
            end
            else if ($urandom_range(0, 1) != 0)
            begin
                // well-formed handle for any slot, often a free one
                pick      = $urandom_range(0, SLOTS - 1);
                rq.handle = make_handle(slot_gen[pick], pick);
            end
        end
        return rq;
    endfunction

    task automatic queue_request(logic [1:0] m, logic [63:0] h, logic [31:0] o, bit hold);
        request_t rq;
        rq.mode   = m;
        rq.handle = h;
        rq.owner  = o;
        rq.hold   = hold;
        request_q.push_back(rq);
    endtask

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    // driver: presents queued requests, idling in bursts
    always @(posedge clk)
    begin : driver
        request_t nxt;
        if (rst_n && !(start && busy))
        begin
            if (start)
            begin
                // transfer at this edge: predict from what is on the ports
                reply_q.push_back(serve_request(mode, handle, owner));
                xfer_count <= xfer_count + 1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
            end
            if (gap_left != 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (request_q.size() == 0
                     || (request_q[0].hold && xfer_count + int'(start) != result_count))
                start <= 1'b0;
            else
            begin
                nxt = request_q.pop_front();
                start  <= 1'b1;
                mode   <= nxt.mode;
                handle <= nxt.handle;
                owner  <= nxt.owner;
            end
        end
    end

    // monitor: every done strobe is a reply, checked against the oldest prediction
    always @(posedge clk)
    begin : monitor
        reply_t want;
        if (rst_n && done)
        begin
            result_count <= result_count + 1;
            if (reply_q.size() == 0)
                flag_mismatch("unexpected reply", {62'd0, status}, '0);
            else
            begin
                want = reply_q.pop_front();
                if (status !== want.status)
                    flag_mismatch("status", {62'd0, status}, {62'd0, want.status});
                if (handle_out !== want.handle)
                    flag_mismatch("handle_out", handle_out, want.handle);
                if (slot_out !== want.slot)
                    flag_mismatch("slot_out", {58'd0, slot_out}, {58'd0, want.slot});
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        request_t rq;
        int       sent;
        int       fills;
        int       batch;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_taken[i]     = 1'b0;
            slot_gen[i]       = GEN_ONE;
            slot_owner_tag[i] = '0;
        end

        // directed part, written against the table as it is after reset
        queue_request(MODE_ALLOC, '0, '0, 1'b0);                              // null owner
        queue_request(MODE_ALLOC, '1, 32'hffff_ffff, 1'b0);                   // slot 0
        queue_request(MODE_ALLOC, '0, 32'h0000_0001, 1'b0);                   // slot 1
        queue_request(MODE_VALIDATE, make_handle(GEN_ONE, 0), 32'hffff_ffff, 1'b0);
        queue_request(MODE_VALIDATE, make_handle(GEN_ONE, 0), 32'h0000_0001, 1'b0);
        queue_request(MODE_VALIDATE, make_handle(GEN_ONE, 0), '0, 1'b0);
        queue_request(MODE_VALIDATE, {8'h40, GEN_ONE, 32'd1}, 32'hffff_ffff, 1'b0);
        queue_request(MODE_VALIDATE, {HANDLE_TAG, GEN_ONE, 32'd0}, 32'hffff_ffff, 1'b0);
        queue_request(MODE_VALIDATE, {HANDLE_TAG, 24'd0, 32'd1}, 32'hffff_ffff, 1'b0);
        queue_request(MODE_VALIDATE, make_handle(GEN_ONE, SLOTS), 32'h0000_0001, 1'b0);
        queue_request(MODE_VALIDATE, make_handle(GEN_ONE, SLOTS - 1), 32'h0000_0001, 1'b0);
        queue_request(MODE_VALIDATE, {HANDLE_TAG, GEN_ONE, 32'hffff_ffff}, 32'd1, 1'b0);
        queue_request(MODE_VALIDATE, make_handle(24'd2, 0), 32'hffff_ffff, 1'b0);
        queue_request(MODE_VALIDATE, make_handle(GEN_ONE, 5), 32'h0000_0001, 1'b0);
        queue_request(MODE_VALIDATE, '1, 32'hffff_ffff, 1'b0);
        queue_request(MODE_UNUSED, make_handle(GEN_ONE, 0), 32'hffff_ffff, 1'b0);
        queue_request(MODE_RELEASE, make_handle(GEN_ONE, 1), 32'h0000_0001, 1'b0);
        queue_request(MODE_VALIDATE, make_handle(GEN_ONE, 1), 32'h0000_0001, 1'b0);  // stale
        queue_request(MODE_RELEASE, make_handle(GEN_ONE, 1), 32'h0000_0001, 1'b0);   // twice
        queue_request(MODE_ALLOC, '0, 32'ha5a5_a5a5, 1'b0);                   // slot 1, gen 2
        queue_request(MODE_VALIDATE, make_handle(24'd2, 1), 32'ha5a5_a5a5, 1'b1);
        queue_request(MODE_RELEASE, make_handle(24'd2, 1), 32'ha5a5_a5a5, 1'b0);
        queue_request(MODE_RELEASE, make_handle(GEN_ONE, 0), 32'hffff_ffff, 1'b0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // random part, refilled in small batches from the current shadow table
        sent  = 0;
        fills = 0;
        while (sent < RANDOM_ITEMS)
        begin
            while (request_q.size() != 0)
                @(negedge clk);
            if (sent / FILL_EVERY > fills)
            begin
                // run the table past full, after a full drain
                fills++;
                for (int i = 0; i < FILL_ITEMS; i++)
                begin
                    queue_request(MODE_ALLOC, {$urandom, $urandom}, $urandom | 32'd1, i == 0);
                end
                sent += FILL_ITEMS;
            end
            else
            begin
                batch = $urandom_range(4, 16);
                for (int b = 0; b < batch; b++)
                begin
                    rq = random_request();
                    if (b == 0 && $urandom_range(0, 14) == 0)
                        rq.hold = 1'b1;
                    request_q.push_back(rq);
                end
                sent += batch;
            end
        end

        while (request_q.size() != 0 || start || result_count != xfer_count)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && reply_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
